/* src/r2h_pkg.sv */
// shared types, constants and field widths for the rgb to hsl converter
package r2h_pkg;

    localparam int RGB_MAX       = 255;
    localparam int HSL_MAX       = 240;
    localparam int GREY_HUE      = 160;

    localparam int CH_W         = 8;
    localparam int SUM_W        = 9;
    localparam int DIV_STAGES   = 8;
    localparam int LUM_NUM_W    = 17;
    localparam int SAT_NUM_W    = 17;
    localparam int DIST_NUM_W   = 16;
    localparam int HUE_W        = 10;
    localparam int PIPE_STAGES  = DIV_STAGES + 3;

    localparam int LUM_LOW_LIMIT = (HSL_MAX / 2 + 1) * 2 * RGB_MAX;

    localparam int     LUM_SHIFT   = LUM_NUM_W + $clog2(2 * RGB_MAX);
    localparam longint LUM_RECIP   = ((64'd1 << LUM_SHIFT) + 2 * RGB_MAX - 1) / (2 * RGB_MAX);
    localparam int     LUM_RECIP_W = $clog2(LUM_RECIP + 1);
    localparam int     LUM_PROD_W  = LUM_NUM_W + LUM_RECIP_W;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_sel;

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic            grey;
        t_sel            sel;
    } t_side;

endpackage

/* src/r2h_prep.sv */
// front stages: channel max and min, sums, all division numerators and the divisors of the dividers
module r2h_prep
    import r2h_pkg::*;
(
    input  logic                  i_clk,
    input  logic [1:0]            i_en,
    input  logic [CH_W-1:0]       i_red,
    input  logic [CH_W-1:0]       i_green,
    input  logic [CH_W-1:0]       i_blue,
    input  logic [CH_W-1:0]       i_alpha,
    output logic [LUM_NUM_W-1:0]  o_lum_num,
    output logic [SAT_NUM_W-1:0]  o_sat_num,
    output logic [SUM_W-1:0]      o_sat_den,
    output logic [DIST_NUM_W-1:0] o_dist_r,
    output logic [DIST_NUM_W-1:0] o_dist_g,
    output logic [DIST_NUM_W-1:0] o_dist_b,
    output logic [CH_W-1:0]       o_dist_den,
    output t_side                 o_side
);

    logic [CH_W-1:0]  r_red, r_green, r_blue, r_max;
    logic [SUM_W-1:0] r_sum;
    logic [CH_W-1:0]  r_delta;
    t_side            r_side1;

    logic [CH_W-1:0]  n_max, n_min;
    t_sel             n_sel;

    always_comb begin
        n_max = i_red;
        n_min = i_red;
        if (i_green > n_max) n_max = i_green;
        if (i_blue > n_max) n_max = i_blue;
        if (i_green < n_min) n_min = i_green;
        if (i_blue < n_min) n_min = i_blue;
        if (i_red == n_max) begin
            n_sel = SEL_RED;
        end else if (i_green == n_max) begin
            n_sel = SEL_GREEN;
        end else begin
            n_sel = SEL_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_red         <= i_red;
            r_green       <= i_green;
            r_blue        <= i_blue;
            r_max         <= n_max;
            r_sum         <= SUM_W'(n_max) + SUM_W'(n_min);
            r_delta       <= n_max - n_min;
            r_side1.alpha <= i_alpha;
            r_side1.grey  <= (n_max == n_min);
            r_side1.sel   <= n_sel;
        end
    end

    logic [LUM_NUM_W-1:0]  n_lum_num;
    logic [SUM_W-1:0]      n_den;
    logic [SAT_NUM_W-1:0]  n_sat_num;
    logic [DIST_NUM_W-1:0] n_dist_r, n_dist_g, n_dist_b;
    logic [DIST_NUM_W-1:0] half_delta;

    always_comb begin
        n_lum_num = LUM_NUM_W'(r_sum) * LUM_NUM_W'(HSL_MAX) + LUM_NUM_W'(RGB_MAX);
        if (n_lum_num < LUM_NUM_W'(LUM_LOW_LIMIT)) begin
            n_den = r_sum;
        end else begin
            n_den = SUM_W'(2 * RGB_MAX) - r_sum;
        end
        if (n_den == '0) n_den = SUM_W'(1);
        n_sat_num = SAT_NUM_W'(r_delta) * SAT_NUM_W'(HSL_MAX)
                  + SAT_NUM_W'(n_den >> 1);
        half_delta = DIST_NUM_W'(r_delta >> 1);
        n_dist_r = DIST_NUM_W'(r_max - r_red) * DIST_NUM_W'(HSL_MAX / 6) + half_delta;
        n_dist_g = DIST_NUM_W'(r_max - r_green) * DIST_NUM_W'(HSL_MAX / 6) + half_delta;
        n_dist_b = DIST_NUM_W'(r_max - r_blue) * DIST_NUM_W'(HSL_MAX / 6) + half_delta;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_lum_num  <= n_lum_num;
            o_sat_num  <= n_sat_num;
            o_sat_den  <= n_den;
            o_dist_r   <= n_dist_r;
            o_dist_g   <= n_dist_g;
            o_dist_b   <= n_dist_b;
            o_dist_den <= r_side1.grey ? CH_W'(1) : r_delta;
            o_side     <= r_side1;
        end
    end

endmodule

/* src/r2h_div.sv */
// pipelined restoring divider, one quotient bit per stage
module r2h_div
    import r2h_pkg::*;
#(
    parameter int N_W = 16,
    parameter int D_W = 8,
    parameter int Q_W = DIV_STAGES
) (
    input  logic           i_clk,
    input  logic [Q_W-1:0] i_en,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [Q_W-1:0] o_quo
);

    localparam int RW = D_W + Q_W;

    logic [RW-1:0]  r_rem [0:Q_W-2];
    logic [RW-1:0]  r_den [0:Q_W-2];
    logic [Q_W-1:0] r_quo [0:Q_W-1];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int K = Q_W - 1 - j;
        logic [RW-1:0]  rem_in, den_in;
        logic [Q_W-1:0] quo_in;
        logic [RW:0]    trial;

        if (j == 0) begin : g_first
            assign rem_in = RW'(i_num);
            assign den_in = RW'(i_den);
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
        end

        assign trial = {1'b0, rem_in} - ({1'b0, den_in} << K);

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_quo[j] <= trial[RW] ? quo_in : (quo_in | (Q_W'(1) << K));
            end
        end

        if (j < Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= trial[RW] ? rem_in : trial[RW-1:0];
                    r_den[j] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

/* src/rgb_to_hsl_converter_top.sv */
// top level of the rgb to hsl converter: stage control, dividers and output stage
// Converts one RGBA pixel per transfer into hue, saturation and lightness on the
// 0..240 scale with rounding, passes alpha through and flags grey pixels (hue 160,
// saturation 0). The pipeline is 11 register stages deep: two front stages, eight
// divider stages that settle one quotient bit each, and the output register. It
// accepts one pixel every clock cycle unless all stages are full and stalled; each
// stage holds behind a full, stalled next stage; empty ones fill while the output waits.
module rgb_to_hsl_converter_top
    import r2h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // hue, saturation, lightness, alpha_out
    output logic        m_axis_tuser    // achromatic
);

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || m_axis_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (stage_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign s_axis_tready = stage_en[0];

    logic [LUM_NUM_W-1:0]  lum_num;
    logic [SAT_NUM_W-1:0]  sat_num;
    logic [SUM_W-1:0]      sat_den;
    logic [DIST_NUM_W-1:0] dist_r, dist_g, dist_b;
    logic [CH_W-1:0]       dist_den;
    t_side                 side2;

    r2h_prep u_prep (
        .i_clk      (i_clk),
        .i_en       (stage_en[1:0]),
        .i_red      (s_axis_tdata[7:0]),
        .i_green    (s_axis_tdata[15:8]),
        .i_blue     (s_axis_tdata[23:16]),
        .i_alpha    (s_axis_tdata[31:24]),
        .o_lum_num  (lum_num),
        .o_sat_num  (sat_num),
        .o_sat_den  (sat_den),
        .o_dist_r   (dist_r),
        .o_dist_g   (dist_g),
        .o_dist_b   (dist_b),
        .o_dist_den (dist_den),
        .o_side     (side2)
    );

    logic [DIV_STAGES-1:0] div_en;
    logic [DIV_STAGES-1:0] q_sat, q_dr, q_dg, q_db;
    logic [CH_W-1:0]       q_lum;

    assign div_en = stage_en[DIV_STAGES+1:2];

    // lightness divides by a constant: reciprocal multiply, then carried along
    logic [LUM_PROD_W-1:0] lum_prod;

    assign lum_prod = LUM_PROD_W'(lum_num) * LUM_PROD_W'(LUM_RECIP);

    r2h_div #(.N_W(SAT_NUM_W), .D_W(SUM_W), .Q_W(DIV_STAGES)) u_div_sat (
        .i_clk (i_clk),
        .i_en  (div_en),
        .i_num (sat_num),
        .i_den (sat_den),
        .o_quo (q_sat)
    );

    r2h_div #(.N_W(DIST_NUM_W), .D_W(CH_W), .Q_W(DIV_STAGES)) u_div_dr (
        .i_clk (i_clk),
        .i_en  (div_en),
        .i_num (dist_r),
        .i_den (dist_den),
        .o_quo (q_dr)
    );

    r2h_div #(.N_W(DIST_NUM_W), .D_W(CH_W), .Q_W(DIV_STAGES)) u_div_dg (
        .i_clk (i_clk),
        .i_en  (div_en),
        .i_num (dist_g),
        .i_den (dist_den),
        .o_quo (q_dg)
    );

    r2h_div #(.N_W(DIST_NUM_W), .D_W(CH_W), .Q_W(DIV_STAGES)) u_div_db (
        .i_clk (i_clk),
        .i_en  (div_en),
        .i_num (dist_b),
        .i_den (dist_den),
        .o_quo (q_db)
    );

    t_side           r_side [0:DIV_STAGES-1];
    logic [CH_W-1:0] r_lum_pipe [0:DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (div_en[0]) begin
            r_side[0]     <= side2;
            r_lum_pipe[0] <= lum_prod[LUM_SHIFT +: CH_W];
        end
        for (int j = 1; j < DIV_STAGES; j++) begin
            if (div_en[j]) begin
                r_side[j]     <= r_side[j-1];
                r_lum_pipe[j] <= r_lum_pipe[j-1];
            end
        end
    end

    assign q_lum = r_lum_pipe[DIV_STAGES-1];

    t_side                   side_last;
    logic signed [HUE_W-1:0] n_hue;
    logic [CH_W-1:0]         n_sat;

    assign side_last = r_side[DIV_STAGES-1];

    always_comb begin
        case (side_last.sel)
            SEL_RED: begin
                n_hue = $signed(HUE_W'(q_db)) - $signed(HUE_W'(q_dg));
            end
            SEL_GREEN: begin
                n_hue = $signed(HUE_W'(HSL_MAX / 3)) + $signed(HUE_W'(q_dr))
                      - $signed(HUE_W'(q_db));
            end
            default: begin
                n_hue = $signed(HUE_W'(2 * HSL_MAX / 3)) + $signed(HUE_W'(q_dg))
                      - $signed(HUE_W'(q_dr));
            end
        endcase
        if (n_hue < 0) n_hue = n_hue + $signed(HUE_W'(HSL_MAX));
        if (n_hue > $signed(HUE_W'(HSL_MAX))) n_hue = n_hue - $signed(HUE_W'(HSL_MAX));
        n_sat = (q_sat > CH_W'(HSL_MAX)) ? CH_W'(HSL_MAX) : q_sat;
        if (side_last.grey) begin
            n_hue = $signed(HUE_W'(GREY_HUE));
            n_sat = '0;
        end
    end

    logic [CH_W-1:0] r_hue, r_sat, r_lum, r_alpha;
    logic            r_grey;

    always_ff @(posedge i_clk) begin
        if (stage_en[PIPE_STAGES-1]) begin
            r_hue   <= n_hue[CH_W-1:0];
            r_sat   <= n_sat;
            r_lum   <= q_lum;
            r_alpha <= side_last.alpha;
            r_grey  <= side_last.grey;
        end
    end

    assign m_axis_tvalid = r_vld[PIPE_STAGES-1];
    assign m_axis_tdata  = {r_alpha, r_lum, r_sat, r_hue};
    assign m_axis_tuser  = r_grey;

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_vld == '1))
        else $error("input blocked while a pipeline stage is empty");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (r_hue <= CH_W'(HSL_MAX)))
        else $error("hue out of range");

    a_grey_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_sat == '0 && r_hue == CH_W'(GREY_HUE)))
        else $error("grey pixel with saturation or defined hue");

    a_levels_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_lum <= CH_W'(HSL_MAX) && r_sat <= CH_W'(HSL_MAX)))
        else $error("lightness or saturation out of range");

endmodule
